@@ rtl/asf_pkg.sv @@
`default_nettype none
package asf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int W         = 32;
    localparam int LANES     = 3;
    localparam int IN_W      = 9 * W;
    localparam int OUT_W     = LANES * W;
    localparam int D_W       = W + 1;                 // exact offset / magnitude
    localparam int SQ_W      = 2 * D_W;               // square of a magnitude, and their sum
    localparam int RT_W      = D_W;                   // root of the sum of squares
    localparam int SR_W      = RT_W + 3;              // partial remainder in the root unit
    localparam int NUM_W     = 2 * D_W + W;           // mag * dist * gain
    localparam int DEN_W     = D_W + FRAC_BITS;       // (radius +- tol) << frac
    localparam int Q_W       = 62;                    // quotient bits kept, larger saturates
    localparam int ADDR_W    = 3;

    localparam logic [W-1:0] ONE_Q = W'(1) << FRAC_BITS;

    typedef enum logic [ADDR_W-1:0] {
        REG_MOVE_AWAY   = 3'd0,
        REG_MAX_SPEED   = 3'd1,
        REG_MAX_FORCE   = 3'd2,
        REG_SLOW_RADIUS = 3'd3,
        REG_RADIUS_TOL  = 3'd4,
        REG_DAMPING     = 3'd5
    } cfg_addr_t;

    // side data that rides along the root unit
    typedef struct packed {
        logic [LANES-1:0][D_W-1:0] mag;
        logic [LANES-1:0]          neg;
        logic [LANES-1:0][W-1:0]   vel;
    } side_t;

    // side data that rides along the first divider
    typedef struct packed {
        logic [LANES-1:0]        neg;
        logic [LANES-1:0][W-1:0] vel;
    } dside_t;

endpackage
`default_nettype wire

@@ rtl/arrive_steering_force.sv @@
`default_nettype none
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  target xyz, agent position xyz, agent velocity xyz
// m_        out  m_tvalid/m_tready  steering force xyz
// cfg_      in   cfg_we             register index and value, no read-back
//
// one request per cycle sustained while m_ is not stalled
// the pipeline holds the 33-stage root unit and two 62-stage divider chains
// rst_n clears the valid bits and loads the register defaults
// a stall on m_ holds every stage in place; s_tready drops only while a held
// result waits at the output
module arrive_steering_force
    import asf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_W-1:0]   s_tdata,   // target_x/y/z, agent_pos_x/y/z, agent_vel_x/y/z
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata,   // force_x, force_y, force_z
    input  wire logic              cfg_we,
    input  wire logic [ADDR_W-1:0] cfg_addr,
    input  wire logic [W-1:0]      cfg_wdata
);

    // configuration registers
    logic         move_away_reg;
    logic [W-1:0] max_speed_reg;
    logic [W-1:0] max_force_reg;
    logic [W-1:0] slow_radius_reg;
    logic [W-1:0] radius_tol_reg;
    logic [W-1:0] damping_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_away_reg   <= 1'b0;
            max_speed_reg   <= ONE_Q;
            max_force_reg   <= ONE_Q;
            slow_radius_reg <= ONE_Q;
            radius_tol_reg  <= '0;
            damping_reg     <= ONE_Q;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MOVE_AWAY:   move_away_reg   <= cfg_wdata[0];
                REG_MAX_SPEED:   max_speed_reg   <= cfg_wdata;
                REG_MAX_FORCE:   max_force_reg   <= cfg_wdata;
                REG_SLOW_RADIUS: slow_radius_reg <= cfg_wdata;
                REG_RADIUS_TOL:  radius_tol_reg  <= cfg_wdata;
                REG_DAMPING:     damping_reg     <= cfg_wdata;
                default:         ;   // unknown index, write dropped
            endcase
        end
    end

    // whole pipeline advances together unless a result is held at the output
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // stage valid bits
    logic a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg;
    logic e_vld_reg, f_vld_reg, g_vld_reg;
    logic h_vld_reg, i_vld_reg, j_vld_reg, k_vld_reg;
    logic out_vld_reg;
    logic sq_vld, dv1_vld, dv2_vld;

    // stage a: offset d
    logic signed [D_W-1:0] a_d_next [LANES];
    logic signed [D_W-1:0] a_d_reg  [LANES];
    logic [LANES-1:0][W-1:0] a_vel_reg;

    always_comb
    begin
        logic signed [D_W-1:0] tx;
        logic signed [D_W-1:0] px;
        for (int i = 0; i < LANES; i++)
        begin
            tx = D_W'(signed'(s_tdata[W*i +: W]));
            px = D_W'(signed'(s_tdata[W*(LANES+i) +: W]));
            a_d_next[i] = move_away_reg ? (px - tx) : (tx - px);
        end
    end

    // stage b: magnitude and sign
    side_t b_side_next;
    side_t b_side_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            b_side_next.neg[i] = a_d_reg[i][D_W-1];
            b_side_next.mag[i] = a_d_reg[i][D_W-1] ? D_W'(-a_d_reg[i]) : D_W'(a_d_reg[i]);
        end
        b_side_next.vel = a_vel_reg;
    end

    // stage c: squares, stage d: sum of squares
    logic [LANES-1:0][SQ_W-1:0] c_sq_reg;
    side_t                      c_side_reg;
    logic [SQ_W-1:0]            d_sum_reg;
    side_t                      d_side_reg;

    // side data aligned with the root unit
    side_t sd_reg [RT_W];
    logic [RT_W-1:0] span;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                a_d_reg[i] <= a_d_next[i];
                a_vel_reg[i] <= s_tdata[W*(2*LANES+i) +: W];
                c_sq_reg[i] <= SQ_W'(b_side_reg.mag[i]) * SQ_W'(b_side_reg.mag[i]);
            end
            b_side_reg <= b_side_next;
            c_side_reg <= b_side_reg;
            d_sum_reg  <= c_sq_reg[0] + c_sq_reg[1] + c_sq_reg[2];
            d_side_reg <= c_side_reg;
            sd_reg[0]  <= d_side_reg;
            for (int k = 1; k < RT_W; k++)
            begin
                sd_reg[k] <= sd_reg[k-1];
            end
        end
    end

    asf_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_vld_reg),
        .rad       (d_sum_reg),
        .out_valid (sq_vld),
        .root      (span)
    );

    // stage e: zone choice, first products, near-zone denominator
    side_t                       e_side;
    logic signed [D_W:0]         e_den;
    logic [LANES-1:0][D_W+W-1:0] e_fnum_reg;
    logic [LANES-1:0][SQ_W-1:0]  e_p1_reg;
    logic [RT_W-1:0]             e_dist_reg;
    logic                        e_far_reg;
    logic                        e_zero_reg;
    logic                        e_den_ok_reg;
    logic [DEN_W-1:0]            e_dd_reg;
    dside_t                      e_ds_reg;

    assign e_side = sd_reg[RT_W-1];
    assign e_den  = move_away_reg
                  ? ($signed({2'b00, slow_radius_reg}) - $signed({2'b00, radius_tol_reg}))
                  : ($signed({2'b00, slow_radius_reg}) + $signed({2'b00, radius_tol_reg}));

    // stage f: near-zone product split in two halves
    logic [LANES-1:0][D_W+W-1:0] f_plo_reg;
    logic [LANES-1:0][D_W+W-1:0] f_phi_reg;
    logic [LANES-1:0][D_W+W-1:0] f_fnum_reg;
    logic [RT_W-1:0]             f_dist_reg;
    logic                        f_far_reg;
    logic                        f_zero_reg;
    logic [DEN_W-1:0]            f_dd_reg;
    dside_t                      f_ds_reg;

    // stage g: divider operands
    logic [LANES-1:0][NUM_W-1:0] g_num_reg;
    logic [DEN_W-1:0]            g_den_reg;
    dside_t                      g_ds_reg;
    dside_t                      dd_reg [Q_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                e_fnum_reg[i] <= (D_W+W)'(e_side.mag[i]) * (D_W+W)'(max_speed_reg);
                e_p1_reg[i]   <= SQ_W'(e_side.mag[i]) * SQ_W'(span);
                f_plo_reg[i]  <= (D_W+W)'(e_p1_reg[i][D_W-1:0]) * (D_W+W)'(damping_reg);
                f_phi_reg[i]  <= (D_W+W)'(e_p1_reg[i][SQ_W-1:D_W]) * (D_W+W)'(damping_reg);
                if (f_zero_reg)
                    g_num_reg[i] <= '0;
                else if (f_far_reg)
                    g_num_reg[i] <= NUM_W'(f_fnum_reg[i]);
                else
                    g_num_reg[i] <= (NUM_W'(f_phi_reg[i]) << D_W) + NUM_W'(f_plo_reg[i]);
            end
            e_dist_reg   <= span;
            e_far_reg    <= move_away_reg ? (span <= RT_W'(slow_radius_reg))
                                          : (span >= RT_W'(slow_radius_reg));
            e_zero_reg   <= (span == '0);
            e_den_ok_reg <= !e_den[D_W] && (e_den != '0);
            e_dd_reg     <= {e_den[D_W-1:0], {FRAC_BITS{1'b0}}};
            e_ds_reg.neg <= e_side.neg;
            e_ds_reg.vel <= e_side.vel;

            f_fnum_reg <= e_fnum_reg;
            f_dist_reg <= e_dist_reg;
            f_far_reg  <= e_far_reg;
            // zero offset, or a near zone with a non-positive denominator
            f_zero_reg <= e_zero_reg || (!e_far_reg && !e_den_ok_reg);
            f_dd_reg   <= e_dd_reg;
            f_ds_reg   <= e_ds_reg;

            if (f_zero_reg)
                g_den_reg <= DEN_W'(1);
            else if (f_far_reg)
                g_den_reg <= DEN_W'(f_dist_reg);
            else
                g_den_reg <= f_dd_reg;
            g_ds_reg <= f_ds_reg;

            dd_reg[0] <= g_ds_reg;
            for (int k = 1; k < Q_W; k++)
            begin
                dd_reg[k] <= dd_reg[k-1];
            end
        end
    end

    // desired magnitude dividers
    logic [LANES-1:0][Q_W-1:0] dv1_q;
    logic [LANES-1:0]          dv1_ovf;
    logic [LANES-1:0]          dv1_v;

    for (genvar i = 0; i < LANES; i++) begin : g_dv1
        asf_div u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (g_vld_reg),
            .num       (g_num_reg[i]),
            .den       (g_den_reg),
            .out_valid (dv1_v[i]),
            .quo       (dv1_q[i]),
            .ovf       (dv1_ovf[i])
        );
    end
    assign dv1_vld = dv1_v[0];

    // stage h: desired minus velocity
    dside_t                       h_side;
    logic signed [63:0]           h_diff_next [LANES];
    logic signed [63:0]           h_diff_reg  [LANES];

    assign h_side = dd_reg[Q_W-1];

    always_comb
    begin
        logic signed [63:0] dmx;
        logic signed [63:0] vx;
        for (int i = 0; i < LANES; i++)
        begin
            // overflowed quotient is saturated to all ones, i.e. 2^62 - 1
            dmx = $signed({2'b00, (dv1_ovf[i] ? {Q_W{1'b1}} : dv1_q[i])});
            vx  = 64'(signed'(h_side.vel[i]));
            h_diff_next[i] = h_side.neg[i] ? (-dmx - vx) : (dmx - vx);
        end
    end

    // stage i: magnitude, stage j: split product, stage k: divider operands
    logic [LANES-1:0][62:0]      i_am_reg;
    logic [LANES-1:0]            i_neg_reg;
    logic [LANES-1:0][63:0]      j_lo_reg;
    logic [LANES-1:0][62:0]      j_hi_reg;
    logic [LANES-1:0]            j_neg_reg;
    logic [LANES-1:0][NUM_W-1:0] k_num_reg;
    logic [DEN_W-1:0]            k_den_reg;
    logic [LANES-1:0]            k_neg_reg;
    logic [LANES-1:0]            kn_reg [Q_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                h_diff_reg[i] <= h_diff_next[i];
                i_neg_reg[i]  <= h_diff_reg[i][63];
                i_am_reg[i]   <= h_diff_reg[i][63] ? 63'(-h_diff_reg[i]) : h_diff_reg[i][62:0];
                j_lo_reg[i]   <= 64'(i_am_reg[i][31:0]) * 64'(max_force_reg);
                j_hi_reg[i]   <= 63'(i_am_reg[i][62:32]) * 63'(max_force_reg);
                k_num_reg[i]  <= (NUM_W'(j_hi_reg[i]) << W) + NUM_W'(j_lo_reg[i]);
            end
            j_neg_reg <= i_neg_reg;
            k_neg_reg <= j_neg_reg;
            k_den_reg <= (max_speed_reg == '0) ? DEN_W'(1) : DEN_W'(max_speed_reg);
            kn_reg[0] <= k_neg_reg;
            for (int k = 1; k < Q_W; k++)
            begin
                kn_reg[k] <= kn_reg[k-1];
            end
        end
    end

    // force dividers
    logic [LANES-1:0][Q_W-1:0] dv2_q;
    logic [LANES-1:0]          dv2_ovf;
    logic [LANES-1:0]          dv2_v;

    for (genvar i = 0; i < LANES; i++) begin : g_dv2
        asf_div u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (k_vld_reg),
            .num       (k_num_reg[i]),
            .den       (k_den_reg),
            .out_valid (dv2_v[i]),
            .quo       (dv2_q[i]),
            .ovf       (dv2_ovf[i])
        );
    end
    assign dv2_vld = dv2_v[0];

    // output stage: saturate, apply sign, zero force when max speed is zero
    logic [OUT_W-1:0] out_next;
    logic [OUT_W-1:0] out_data_reg;

    always_comb
    begin
        logic [W-1:0] m;
        for (int i = 0; i < LANES; i++)
        begin
            if (!kn_reg[Q_W-1][i])
            begin
                m = (dv2_ovf[i] || dv2_q[i] > Q_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                                    : dv2_q[i][W-1:0];
            end
            else
            begin
                m = (dv2_ovf[i] || dv2_q[i] > Q_W'(32'h8000_0000)) ? 32'h8000_0000
                                                                    : dv2_q[i][W-1:0];
                m = -m;
            end
            out_next[W*i +: W] = (max_speed_reg == '0) ? '0 : m;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            g_vld_reg   <= 1'b0;
            h_vld_reg   <= 1'b0;
            i_vld_reg   <= 1'b0;
            j_vld_reg   <= 1'b0;
            k_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg   <= s_tvalid;
            b_vld_reg   <= a_vld_reg;
            c_vld_reg   <= b_vld_reg;
            d_vld_reg   <= c_vld_reg;
            e_vld_reg   <= sq_vld;
            f_vld_reg   <= e_vld_reg;
            g_vld_reg   <= f_vld_reg;
            h_vld_reg   <= dv1_vld;
            i_vld_reg   <= h_vld_reg;
            j_vld_reg   <= i_vld_reg;
            k_vld_reg   <= j_vld_reg;
            out_vld_reg <= dv2_vld;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // accepted request lands in the first stage
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> a_vld_reg)
        else $error("accepted request missing from first stage");

    // a stall freezes every valid bit
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable({a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, e_vld_reg, f_vld_reg,
                         g_vld_reg, h_vld_reg, i_vld_reg, j_vld_reg, k_vld_reg}))
        else $error("pipeline moved during stall");

    // the desired-velocity divider never sees a zero divisor
    a_den: assert property (@(posedge clk) disable iff (!rst_n)
        g_vld_reg |-> (g_den_reg != '0))
        else $error("zero divisor in desired stage");

    // a finished force reaches the output register
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        (en && dv2_vld) |=> m_tvalid)
        else $error("finished force lost before output");

endmodule
`default_nettype wire

@@ rtl/asf_sqrt.sv @@
`default_nettype none
module asf_sqrt
    import asf_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [SQ_W-1:0] rad,
    output logic                 out_valid,
    output logic [RT_W-1:0]      root
);

    // one result bit per stage, two radicand bits consumed per stage
    logic [SQ_W-1:0] x_reg [RT_W];
    logic [SR_W-1:0] r_reg [RT_W];
    logic [RT_W-1:0] q_reg [RT_W];
    logic [RT_W-1:0] v_reg;

    for (genvar k = 0; k < RT_W; k++) begin : g_st
        logic [SQ_W-1:0] xi;
        logic [SR_W-1:0] ri;
        logic [SR_W-1:0] rs;
        logic [SR_W-1:0] tr;
        logic [RT_W-1:0] qi;
        logic            ge;

        if (k == 0) begin : g_first
            assign xi = rad;
            assign ri = '0;
            assign qi = '0;
        end else begin : g_rest
            assign xi = x_reg[k-1];
            assign ri = r_reg[k-1];
            assign qi = q_reg[k-1];
        end

        assign rs = {ri[SR_W-3:0], xi[SQ_W-1 -: 2]};
        assign tr = SR_W'({qi, 2'b01});
        assign ge = (rs >= tr);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k] <= xi << 2;
                r_reg[k] <= ge ? (rs - tr) : rs;
                q_reg[k] <= {qi[RT_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[RT_W-2:0], in_valid};
        end
    end

    assign out_valid = v_reg[RT_W-1];
    assign root      = q_reg[RT_W-1];

endmodule
`default_nettype wire

@@ rtl/asf_div.sv @@
`default_nettype none
module asf_div
    import asf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  out_valid,
    output logic [Q_W-1:0]        quo,
    output logic                  ovf
);

    // restoring division, one quotient bit per stage; numerator low bits
    // shift out of nq while quotient bits shift in
    logic [Q_W-1:0]   nq_reg [Q_W];
    logic [DEN_W-1:0] r_reg  [Q_W];
    logic [DEN_W-1:0] d_reg  [Q_W];
    logic             o_reg  [Q_W];
    logic [Q_W-1:0]   v_reg;

    logic over_in;
    assign over_in = (DEN_W'(num[NUM_W-1:Q_W]) >= den);

    for (genvar k = 0; k < Q_W; k++) begin : g_st
        logic [Q_W-1:0]   ni;
        logic [DEN_W-1:0] ri;
        logic [DEN_W-1:0] di;
        logic             oi;
        logic [DEN_W:0]   rs;
        logic             ge;

        if (k == 0) begin : g_first
            assign ni = num[Q_W-1:0];
            assign ri = DEN_W'(num[NUM_W-1:Q_W]);
            assign di = den;
            assign oi = over_in;
        end else begin : g_rest
            assign ni = nq_reg[k-1];
            assign ri = r_reg[k-1];
            assign di = d_reg[k-1];
            assign oi = o_reg[k-1];
        end

        assign rs = {ri, ni[Q_W-1]};
        assign ge = (rs >= {1'b0, di});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nq_reg[k] <= {ni[Q_W-2:0], ge};
                r_reg[k]  <= ge ? DEN_W'(rs - {1'b0, di}) : DEN_W'(rs);
                d_reg[k]  <= di;
                o_reg[k]  <= oi;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[Q_W-2:0], in_valid};
        end
    end

    assign out_valid = v_reg[Q_W-1];
    assign quo       = nq_reg[Q_W-1];
    assign ovf       = o_reg[Q_W-1];

endmodule
`default_nettype wire

@@ tb/arrive_steering_force_tb.sv @@
`default_nettype none
module arrive_steering_force_tb;
    import asf_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int DRAIN_CYCLES = 200;              // a bit more than the pipeline latency
    localparam logic [ADDR_W-1:0] REG_SPARE = 3'd7;  // index with no register behind it
    localparam logic [63:0] DESIRED_CAP = (64'd1 << 62) - 64'd1;

    typedef struct {
        logic [W-1:0] fx;
        logic [W-1:0] fy;
        logic [W-1:0] fz;
    } force_t;

    // arrive force predictor with its own register copy and a queue of expected forces
    class arrive_scoreboard;
        logic         away;
        logic [W-1:0] spd_max;
        logic [W-1:0] frc_max;
        logic [W-1:0] radius;
        logic [W-1:0] tol;
        logic [W-1:0] gain;
        force_t       pending[$];
        int           errors;

        function new();
            away    = 1'b0;
            spd_max = ONE_Q;
            frc_max = ONE_Q;
            radius  = ONE_Q;
            tol     = '0;
            gain    = ONE_Q;
            errors  = 0;
        endfunction

        function void write_reg(logic [ADDR_W-1:0] idx, logic [W-1:0] val);
            case (idx)
                REG_MOVE_AWAY:   away    = val[0];
                REG_MAX_SPEED:   spd_max = val;
                REG_MAX_FORCE:   frc_max = val;
                REG_SLOW_RADIUS: radius  = val;
                REG_RADIUS_TOL:  tol     = val;
                REG_DAMPING:     gain    = val;
                default: ;
            endcase
        endfunction

        function logic [127:0] root_floor(logic [127:0] v);
            logic [127:0] r;
            logic [127:0] c;
            r = '0;
            for (int b = 34; b >= 0; b--)
            begin
                c = r | (128'd1 << b);
                if (c * c <= v)
                    r = c;
            end
            return r;
        endfunction

        function force_t arrive_force(logic [IN_W-1:0] req);
            logic signed [33:0]  tgt, pos, off;
            logic [33:0]         ab;
            logic [127:0]        mag[3];
            logic                neg[3];
            logic [127:0]        dm[3];
            logic [127:0]        sq, span, q, dd;
            logic signed [34:0]  den;
            logic signed [127:0] des, vel, diff;
            logic [127:0]        am;
            logic [W-1:0]        res[3];
            logic                far;
            force_t              f;
            sq = '0;
            for (int i = 0; i < 3; i++)
            begin
                tgt = $signed(req[W*i +: W]);
                pos = $signed(req[W*(3+i) +: W]);
                off = away ? pos - tgt : tgt - pos;
                neg[i] = off < 0;
                ab = neg[i] ? -off : off;
                mag[i] = {94'd0, ab};
                sq = sq + mag[i] * mag[i];
                dm[i] = '0;
            end
            span = root_floor(sq);
            far = away ? (span <= {96'd0, radius}) : (span >= {96'd0, radius});
            den = away ? $signed({3'd0, radius}) - $signed({3'd0, tol})
                       : $signed({3'd0, radius}) + $signed({3'd0, tol});
            if (span != 0)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (far)
                        q = (mag[i] * {96'd0, spd_max}) / span;
                    else if (den > 0)
                    begin
                        dd = {93'd0, den} << FRAC_BITS;
                        q = (mag[i] * span * {96'd0, gain}) / dd;
                    end
                    else
                        q = '0;
                    dm[i] = (q > {64'd0, DESIRED_CAP}) ? {64'd0, DESIRED_CAP} : q;
                end
            end
            for (int i = 0; i < 3; i++)
            begin
                res[i] = '0;
                if (spd_max != 0)
                begin
                    des = $signed(dm[i]);
                    if (neg[i])
                        des = -des;
                    vel = $signed(req[W*(6+i) +: W]);
                    diff = des - vel;
                    am = (diff < 0) ? -diff : diff;
                    q = (am * {96'd0, frc_max}) / {96'd0, spd_max};
                    if (diff >= 0)
                        res[i] = (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[W-1:0];
                    else
                        res[i] = (q > 128'h8000_0000) ? 32'h8000_0000 : -q[W-1:0];
                end
            end
            f.fx = res[0];
            f.fy = res[1];
            f.fz = res[2];
            return f;
        endfunction

        function void note_request(logic [IN_W-1:0] req);
            pending.push_back(arrive_force(req));
        endfunction

        function void check_force(logic [OUT_W-1:0] got);
            force_t e;
            if (pending.size() == 0)
            begin
                $error("force %h with no request outstanding", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got[W-1:0] !== e.fx)
            begin
                $error("force_x expected %h got %h", e.fx, got[W-1:0]);
                errors++;
            end
            if (got[2*W-1:W] !== e.fy)
            begin
                $error("force_y expected %h got %h", e.fy, got[2*W-1:W]);
                errors++;
            end
            if (got[3*W-1:2*W] !== e.fz)
            begin
                $error("force_z expected %h got %h", e.fz, got[3*W-1:2*W]);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;    // target_x/y/z, agent_pos_x/y/z, agent_vel_x/y/z
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;         // force_x, force_y, force_z
    logic              cfg_we = 1'b0;
    logic [ADDR_W-1:0] cfg_addr = '0;
    logic [W-1:0]      cfg_wdata = '0;

    arrive_steering_force dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    arrive_scoreboard sb = new();
    int  cycles = 0;
    int  stall_left = 0;
    bit  quiet = 1'b0;       // no idling on either side in the final stretch

    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: check on the handshake, then pick next cycle's ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_force(m_tdata);
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left <= $urandom_range(0, 12);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // one register write per edge; the caller lowers cfg_we after the last one
    task automatic write_reg(logic [ADDR_W-1:0] idx, logic [W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic set_regs(logic a, logic [W-1:0] spd, logic [W-1:0] frc,
                            logic [W-1:0] rad, logic [W-1:0] tl, logic [W-1:0] gn);
        write_reg(REG_MOVE_AWAY, {31'd0, a});
        write_reg(REG_MAX_SPEED, spd);
        write_reg(REG_MAX_FORCE, frc);
        write_reg(REG_SLOW_RADIUS, rad);
        write_reg(REG_RADIUS_TOL, tl);
        write_reg(REG_DAMPING, gn);
        // unmapped index must leave every register alone
        write_reg(REG_SPARE, $urandom);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // hold one request until taken, then an optional random gap
    task automatic send_request(logic [IN_W-1:0] req);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(req);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and wait for every outstanding force, then for the pipe to empty
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [W-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 65535) - 32768;
            2: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            default: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
        endcase
    endfunction

    // mostly nearby target so both zones get hit, sometimes anything at all
    function automatic logic [IN_W-1:0] rand_request();
        logic [W-1:0] pos[3], tgt[3], vel[3];
        int           spread;
        spread = $urandom_range(0, 4);
        for (int i = 0; i < 3; i++)
        begin
            pos[i] = rand_coord();
            vel[i] = rand_coord();
            case (spread)
                0: tgt[i] = $urandom;
                1: tgt[i] = pos[i];
                2: tgt[i] = pos[i] + ($urandom_range(0, 32'h0001_0000) - 32'h8000);
                3: tgt[i] = pos[i] + ($urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
                default: tgt[i] = pos[i] + ($urandom >> $urandom_range(0, 31));
            endcase
        end
        return {vel[2], vel[1], vel[0], pos[2], pos[1], pos[0], tgt[2], tgt[1], tgt[0]};
    endfunction

    function automatic logic [IN_W-1:0] pack_req(logic [W-1:0] t, logic [W-1:0] p,
                                                 logic [W-1:0] v);
        return {v, v, v, p, p, p, t, t, t};
    endfunction

    initial
    begin
        int phases;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset defaults
        send_request(pack_req(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        send_request(pack_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_request(pack_req(32'h1234_5678, 32'h1234_5678, 32'h0000_0000));    // zero offset
        send_request(pack_req(32'h0001_0000, 32'h0000_0000, 32'h0000_0000));    // far zone, each axis one radius out
        send_request(pack_req(32'h0000_8000, 32'h0000_0000, 32'hFFFF_0000));    // near zone
        send_request(pack_req(32'h0000_0001, 32'h0000_0000, 32'h7FFF_FFFF));
        send_request(pack_req(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000));
        send_request({288{1'b1}});
        send_request('0);
        drain();

        // huge speed and force: desired cap and force overflow
        set_regs(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(pack_req(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        send_request(pack_req(32'h0000_4000, 32'h0000_0000, 32'h0000_0000));
        send_request(pack_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        drain();

        // zero max speed
        set_regs(1'b0, 32'h0, 32'hFFFF_FFFF, ONE_Q, 32'h0, ONE_Q);
        send_request(pack_req(32'h0002_0000, 32'h0000_0000, 32'h1234_5678));
        send_request(pack_req(32'h0000_4000, 32'h0000_0000, 32'h8000_0000));
        drain();

        // away mode with tolerance above radius: bad denominator
        set_regs(1'b1, ONE_Q, ONE_Q, 32'h0000_8000, 32'h0001_0000, ONE_Q);
        send_request(pack_req(32'h0004_0000, 32'h0000_0000, 32'h0000_0000));
        send_request(pack_req(32'h0000_1000, 32'h0000_0000, 32'h0000_1000));
        send_request(pack_req(32'h0000_8000, 32'h0000_0000, 32'h0000_0000));  // each axis at radius, distance beyond it
        drain();

        // zero radius, zero gain
        set_regs(1'b0, ONE_Q, ONE_Q, 32'h0, 32'h0, 32'h0);
        send_request(pack_req(32'h0000_0001, 32'h0000_0000, 32'h0000_0000));
        send_request(pack_req(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF));
        drain();

        // random phases, each with its own register setting
        phases = 8;
        for (int ph = 0; ph < phases; ph++)
        begin
            case (ph)
                0: set_regs(1'b0, ONE_Q, ONE_Q, ONE_Q, 32'h0, ONE_Q);
                1: set_regs(1'b1, ONE_Q, 32'h0002_0000, 32'h0002_0000, 32'h0000_8000, 32'h0000_C000);
                2: set_regs(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF);
                3: set_regs(1'b1, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 32'h0, ONE_Q);
                4: set_regs(1'b1, $urandom, $urandom, $urandom_range(0, 32'h0008_0000),
                            $urandom_range(0, 32'h0008_0000), $urandom);
                5: set_regs(1'b0, $urandom_range(0, 1) ? 32'h0 : ONE_Q, 32'h0, ONE_Q, 32'h0, ONE_Q);
                default: set_regs($urandom_range(0, 1), $urandom_range(1, 32'h0004_0000),
                                  $urandom_range(0, 32'h0004_0000),
                                  $urandom_range(0, 32'h0004_0000),
                                  $urandom_range(0, 32'h0001_0000), $urandom);
            endcase
            if (ph == phases - 1)
                quiet = 1'b1;
            for (int n = 0; n < 190; n++)
                send_request(rand_request());
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire

@@ filelist.f @@
rtl/asf_pkg.sv
rtl/asf_sqrt.sv
rtl/asf_div.sv
rtl/arrive_steering_force.sv
tb/arrive_steering_force_tb.sv
